/* rtl/tdp_pkg.sv */
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared constants, types and tables of the thumbstick deadzone polar unit.
// ----------------------------------------------------------------------------
package tdp_pkg;

   localparam int AXIS_MAX      = 32767;
   localparam int ONE_Q14       = 16384;
   localparam int CORDIC_STEPS  = 18;
   localparam int DIV_STEPS     = 15;
   localparam int SQRT_STEPS    = 16;
   localparam int ANGLE_LIMIT   = 11520;
   localparam int DEG180_FINE   = 2949120;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = 2;

   localparam logic CSR_DEADZONE_LEFT  = 1'b0;
   localparam logic CSR_DEADZONE_RIGHT = 1'b1;

   // one classified sample handed from front to back
   typedef struct packed {
      logic        stick;
      logic        neg_x;
      logic        neg_y;
      logic        live_x;
      logic        live_y;
      logic [14:0] num_x;
      logic [14:0] num_y;
      logic [15:0] den;
   } front_item_type;

   function automatic logic signed [23:0] atan_fine(input int i);
      case (i)
         0:  atan_fine = 24'sd737280;
         1:  atan_fine = 24'sd435242;
         2:  atan_fine = 24'sd229970;
         3:  atan_fine = 24'sd116736;
         4:  atan_fine = 24'sd58595;
         5:  atan_fine = 24'sd29326;
         6:  atan_fine = 24'sd14667;
         7:  atan_fine = 24'sd7334;
         8:  atan_fine = 24'sd3667;
         9:  atan_fine = 24'sd1833;
         10: atan_fine = 24'sd917;
         11: atan_fine = 24'sd458;
         12: atan_fine = 24'sd229;
         13: atan_fine = 24'sd115;
         14: atan_fine = 24'sd57;
         15: atan_fine = 24'sd29;
         16: atan_fine = 24'sd14;
         17: atan_fine = 24'sd7;
         default: atan_fine = 24'sd0;
      endcase
   endfunction

endpackage

/* rtl/thumbstick_deadzone_polar_unit.sv */
// ----------------------------------------------------------------------------
// thumbstick_deadzone_polar_unit
// Axial deadzone, Q2.14 normalization, angle and magnitude of stick samples.
// ----------------------------------------------------------------------------
// One sample is taken every cycle unless req_stall holds it off; each result
// passes through the back pipeline (15 divider stages, 18 CORDIC
// stages and a few registers). The front clamps and subtracts the deadzone
// in one stage and feeds a four-entry queue, so the back may stall on its own.
module thumbstick_deadzone_polar_unit import tdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [14:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_stick_select,
   input  logic [15:0] req_raw_x,
   input  logic [15:0] req_raw_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_stick_echo,
   output logic [15:0] rsp_norm_x,
   output logic [15:0] rsp_norm_y,
   output logic [14:0] rsp_angle,
   output logic [14:0] rsp_magnitude
);

   logic           f_valid, f_stall, q_valid, q_stall;
   front_item_type f_item, q_item;

   tdp_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .in_valid(req_valid), .in_stall(req_stall), .in_stick(req_stick_select),
      .in_x(req_raw_x), .in_y(req_raw_y),
      .out_valid(f_valid), .out_stall(f_stall), .out_item(f_item)
   );

   tdp_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_item(f_item),
      .out_valid(q_valid), .out_stall(q_stall), .out_item(q_item)
   );

   tdp_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_stall(q_stall), .in_item(q_item),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_stick(rsp_stick_echo),
      .out_x(rsp_norm_x), .out_y(rsp_norm_y), .out_angle(rsp_angle),
      .out_mag(rsp_magnitude)
   );

endmodule

/* rtl/tdp_front.sv */
// ----------------------------------------------------------------------------
// tdp_front
// Accepts samples, clamps each axis and subtracts the selected deadzone.
// ----------------------------------------------------------------------------
module tdp_front import tdp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write,
   input  logic           csr_index,
   input  logic [14:0]    csr_data,
   input  logic           in_valid,
   output logic           in_stall,
   input  logic           in_stick,
   input  logic [15:0]    in_x,
   input  logic [15:0]    in_y,
   output logic           out_valid,
   input  logic           out_stall,
   output front_item_type out_item
);

   logic [14:0]    dz_left_ff, dz_right_ff;
   logic           valid_ff;
   front_item_type item_ff, item_in;
   logic [14:0]    dz;

   function automatic logic [15:0] clamp_abs(input logic [15:0] v);
      logic [15:0] a;
      a = v[15] ? (16'd0 - v) : v;
      if (a > 16'd32767) a = 16'd32767;
      clamp_abs = a;
   endfunction

   logic [15:0] ax, ay;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_left_ff  <= 15'd7849;
         dz_right_ff <= 15'd8689;
      end else if (csr_write) begin
         if (csr_index == CSR_DEADZONE_LEFT) dz_left_ff <= csr_data;
         else dz_right_ff <= csr_data;
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_comb begin
      dz = in_stick ? dz_right_ff : dz_left_ff;
      ax = clamp_abs(in_x);
      ay = clamp_abs(in_y);
      item_in.stick  = in_stick;
      item_in.neg_x  = in_x[15];
      item_in.neg_y  = in_y[15];
      item_in.live_x = ax > {1'b0, dz};
      item_in.live_y = ay > {1'b0, dz};
      item_in.num_x  = 15'(ax - {1'b0, dz});
      item_in.num_y  = 15'(ay - {1'b0, dz});
      item_in.den    = 16'(AXIS_MAX) - {1'b0, dz};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (!in_stall) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* rtl/tdp_queue.sv */
// ----------------------------------------------------------------------------
// tdp_queue
// Short queue between the front and the back part.
// ----------------------------------------------------------------------------
module tdp_queue import tdp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_stall,
   input  front_item_type in_item,
   output logic           out_valid,
   input  logic           out_stall,
   output front_item_type out_item
);

   front_item_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ff, rd_ff;
   logic [QUEUE_AW:0]       count_ff;
   logic                    push, pop;

   assign in_stall  = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_item  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");
   assert property (@(posedge clock) disable iff (reset)
      ((QUEUE_AW+1)'(wr_ff - rd_ff) & (QUEUE_AW+1)'(QUEUE_DEPTH-1))
      == (count_ff & (QUEUE_AW+1)'(QUEUE_DEPTH-1)))
      else $error("queue pointers disagree with count");

endmodule

/* rtl/tdp_back.sv */
// ----------------------------------------------------------------------------
// tdp_back
// Pipelined divide, CORDIC angle and square root of the normalized vector.
// ----------------------------------------------------------------------------
module tdp_back import tdp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_stall,
   input  front_item_type in_item,
   output logic           out_valid,
   input  logic           out_stall,
   output logic           out_stick,
   output logic [15:0]    out_x,
   output logic [15:0]    out_y,
   output logic [14:0]    out_angle,
   output logic [14:0]    out_mag
);

   localparam int NS = DIV_STEPS + 2 + CORDIC_STEPS + 2;
   localparam int DS = DIV_STEPS + 1;         // divider stages
   localparam int CS = DS + 1;                // cordic first stage
   localparam int ES = CS + CORDIC_STEPS;     // last cordic stage

   logic adv;
   logic v_ff [NS];
   assign adv = !(v_ff[NS-1] && out_stall);
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) v_ff[s] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < NS; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   // restoring divide: q = floor((2*num*16384 + den) / (2*den)), one bit a stage
   // numerator 2*num*2^14+den < 2^31, quotient at most 16384 (15 bits)
   logic [31:0] rx_ff [DS], ry_ff [DS];
   logic [14:0] qx_ff [DS], qy_ff [DS];
   logic [16:0] d2_ff [DS];
   logic        st_ff [DS], nx_ff [DS], ny_ff [DS], lx_ff [DS], ly_ff [DS];

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff[0] <= {2'b0, in_item.num_x, 15'b0} + 32'(in_item.den);
         ry_ff[0] <= {2'b0, in_item.num_y, 15'b0} + 32'(in_item.den);
         qx_ff[0] <= '0;
         qy_ff[0] <= '0;
         d2_ff[0] <= {in_item.den, 1'b0};
         st_ff[0] <= in_item.stick;
         nx_ff[0] <= in_item.neg_x;
         ny_ff[0] <= in_item.neg_y;
         lx_ff[0] <= in_item.live_x;
         ly_ff[0] <= in_item.live_y;
         for (int s = 1; s < DS; s++) begin
            automatic int b = DIV_STEPS - s;
            automatic logic [31:0] tx = 32'(d2_ff[s-1]) << b;
            automatic logic [31:0] ty = 32'(d2_ff[s-1]) << b;
            if (rx_ff[s-1] >= tx) begin
               rx_ff[s] <= rx_ff[s-1] - tx;
               qx_ff[s] <= qx_ff[s-1] | (15'd1 << b);
            end else begin
               rx_ff[s] <= rx_ff[s-1];
               qx_ff[s] <= qx_ff[s-1];
            end
            if (ry_ff[s-1] >= ty) begin
               ry_ff[s] <= ry_ff[s-1] - ty;
               qy_ff[s] <= qy_ff[s-1] | (15'd1 << b);
            end else begin
               ry_ff[s] <= ry_ff[s-1];
               qy_ff[s] <= qy_ff[s-1];
            end
            d2_ff[s] <= d2_ff[s-1];
            st_ff[s] <= st_ff[s-1];
            nx_ff[s] <= nx_ff[s-1];
            ny_ff[s] <= ny_ff[s-1];
            lx_ff[s] <= lx_ff[s-1];
            ly_ff[s] <= ly_ff[s-1];
         end
      end
   end

   // stage DS: apply sign and zero, 16 stages of the divider stop at b = 0
   logic signed [15:0] sx_ff, sy_ff;
   logic               st2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         automatic logic [15:0] qx = lx_ff[DS-1] ? {1'b0, qx_ff[DS-1]} : 16'd0;
         automatic logic [15:0] qy = ly_ff[DS-1] ? {1'b0, qy_ff[DS-1]} : 16'd0;
         sx_ff  <= nx_ff[DS-1] ? -qx : qx;
         sy_ff  <= ny_ff[DS-1] ? -qy : qy;
         st2_ff <= st_ff[DS-1];
      end
   end

   // cordic stages plus square root carried alongside
   logic signed [29:0] cx_ff [CORDIC_STEPS+1], cy_ff [CORDIC_STEPS+1];
   logic signed [23:0] cz_ff [CORDIC_STEPS+1];
   logic signed [15:0] ox_ff [CORDIC_STEPS+1], oy_ff [CORDIC_STEPS+1];
   logic               os_ff [CORDIC_STEPS+1];
   // sum of squares reaches 2^29 when both axes are at full scale
   logic [29:0]        sq_ff [CORDIC_STEPS+1];
   logic [29:0]        rm_ff [CORDIC_STEPS+1];
   logic [14:0]        rt_ff [CORDIC_STEPS+1];

   function automatic logic signed [29:0] tsh(input logic signed [29:0] v, input int s);
      logic [29:0] a;
      a = v[29] ? -v : v;
      a = a >> s;
      tsh = v[29] ? -$signed(a) : $signed(a);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         automatic logic signed [29:0] x0 = 30'(sx_ff) <<< 12;
         automatic logic signed [29:0] y0 = 30'(sy_ff) <<< 12;
         automatic logic signed [31:0] px = sx_ff * sx_ff;
         automatic logic signed [31:0] py = sy_ff * sy_ff;
         if (x0 < 0) begin
            cz_ff[0] <= (y0 >= 0) ? 24'(DEG180_FINE) : -24'(DEG180_FINE);
            cx_ff[0] <= -x0;
            cy_ff[0] <= -y0;
         end else begin
            cz_ff[0] <= '0;
            cx_ff[0] <= x0;
            cy_ff[0] <= y0;
         end
         ox_ff[0] <= sx_ff;
         oy_ff[0] <= sy_ff;
         os_ff[0] <= st2_ff;
         sq_ff[0] <= 30'(px) + 30'(py);
         rm_ff[0] <= 30'(px) + 30'(py);
         rt_ff[0] <= '0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            automatic logic signed [29:0] x = cx_ff[i];
            automatic logic signed [29:0] y = cy_ff[i];
            if (y > 0) begin
               cx_ff[i+1] <= x + tsh(y, i);
               cy_ff[i+1] <= y - tsh(x, i);
               cz_ff[i+1] <= cz_ff[i] + atan_fine(i);
            end else if (y < 0) begin
               cx_ff[i+1] <= x - tsh(y, i);
               cy_ff[i+1] <= y + tsh(x, i);
               cz_ff[i+1] <= cz_ff[i] - atan_fine(i);
            end else begin
               cx_ff[i+1] <= x;
               cy_ff[i+1] <= y;
               cz_ff[i+1] <= cz_ff[i];
            end
            ox_ff[i+1] <= ox_ff[i];
            oy_ff[i+1] <= oy_ff[i];
            os_ff[i+1] <= os_ff[i];
            sq_ff[i+1] <= sq_ff[i];
            // one root bit a stage over the first fifteen stages
            if (i < 15) begin
               automatic int b = 14 - i;
               automatic logic [29:0] tr = {15'(rt_ff[i] | (15'd1 << b)), 15'b0} >> 0;
               automatic logic [29:0] t2 = 30'((30'(rt_ff[i] | (15'd1 << b))) *
                                               (30'(rt_ff[i] | (15'd1 << b))));
               if (t2 <= sq_ff[i] && tr != 30'b1) rt_ff[i+1] <= rt_ff[i] | (15'd1 << b);
               else rt_ff[i+1] <= rt_ff[i];
               rm_ff[i+1] <= rm_ff[i];
            end else begin
               rt_ff[i+1] <= rt_ff[i];
               rm_ff[i+1] <= sq_ff[i] - 30'(30'(rt_ff[i]) * 30'(rt_ff[i]));
            end
         end
      end
   end

   // output stage: round and clamp angle, round and saturate magnitude
   logic               os_o_ff;
   logic [15:0]        ox_o_ff, oy_o_ff;
   logic [14:0]        ang_o_ff, mag_o_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         automatic logic signed [23:0] r =
            24'((cz_ff[CORDIC_STEPS] + 24'sd128) >>> 8);
         automatic logic [15:0] m = {1'b0, rt_ff[CORDIC_STEPS]};
         if (rm_ff[CORDIC_STEPS] > 30'(rt_ff[CORDIC_STEPS])) m = m + 1'b1;
         if (m > 16'(ONE_Q14)) m = 16'(ONE_Q14);
         if (r > 24'sd11520) r = 24'(ANGLE_LIMIT);
         if (r < -24'sd11520) r = -24'(ANGLE_LIMIT);
         os_o_ff  <= os_ff[CORDIC_STEPS];
         ox_o_ff  <= ox_ff[CORDIC_STEPS];
         oy_o_ff  <= oy_ff[CORDIC_STEPS];
         ang_o_ff <= r[14:0];
         mag_o_ff <= m[14:0];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_stick = os_o_ff;
   assign out_x     = ox_o_ff;
   assign out_y     = oy_o_ff;
   assign out_angle = ang_o_ff;
   assign out_mag   = mag_o_ff;

   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_mag <= 15'(ONE_Q14))
      else $error("magnitude above one");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_stall) |=> out_valid && $stable(out_angle))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_x == 16'd0 && out_y == 16'd0) |-> out_angle == 15'd0)
      else $error("zero vector gives nonzero angle");

endmodule
